@@ hw/rtl/heightmap_vertex_normals_assert.svh @@
// Assertion macros for the height-map vertex normal block.
// Depends on a clock clk and an active-low reset rst_n in the including scope.
`ifndef HEIGHTMAP_VERTEX_NORMALS_ASSERT_SVH
`define HEIGHTMAP_VERTEX_NORMALS_ASSERT_SVH

// Same-cycle implication
`define HVN_ASSERT_NOW(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) else $error(msg);

// Next-cycle implication
`define HVN_ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) else $error(msg);

`endif

@@ hw/rtl/hvn_pkg.sv @@
// Shared types, constants and vector helpers for the height-map vertex normal block.
// No dependencies.
package hvn_pkg;

    localparam int MAX_COLUMNS_DEFAULT = 1024;
    localparam int HEIGHT_W            = 16;
    localparam int ROW_W               = 16;
    localparam int COLUMN_COUNT_W      = 11;
    localparam int VERTEX_COLUMN_W     = 10;
    localparam int NORMAL_W            = 16;
    localparam int SUM_W               = 20;
    localparam int CFG_INDEX_W         = 1;
    localparam int CFG_DATA_W          = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 1'd1;

    localparam logic [ROW_W-1:0]          ROW_COUNT_RESET    = 16'd2;
    localparam logic [COLUMN_COUNT_W-1:0] COLUMN_COUNT_RESET = 11'd1024;

    localparam logic signed [SUM_W-1:0] NEG_GRID_UNIT = -20'sd256;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } sum_vec_t;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] x;
        logic signed [NORMAL_W-1:0] y;
        logic signed [NORMAL_W-1:0] z;
    } normal_vec_t;

    function automatic sum_vec_t widen(normal_vec_t n);
        sum_vec_t w;
        w.x = SUM_W'(n.x);
        w.y = SUM_W'(n.y);
        w.z = SUM_W'(n.z);
        return w;
    endfunction

    function automatic sum_vec_t vec_add(sum_vec_t a, sum_vec_t b);
        sum_vec_t s;
        s.x = a.x + b.x;
        s.y = a.y + b.y;
        s.z = a.z + b.z;
        return s;
    endfunction

endpackage

@@ hw/rtl/hvn_height_if.sv @@
// Input channel carrying one height sample per transaction.
// Depends on hvn_pkg.
interface hvn_height_if;
    import hvn_pkg::*;
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] height;
    modport source (output valid, output height, input ready);
    modport sink (input valid, input height, output ready);
endinterface

@@ hw/rtl/hvn_normal_if.sv @@
// Output channel carrying one vertex normal per transaction.
// Depends on hvn_pkg.
interface hvn_normal_if;
    import hvn_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [ROW_W-1:0]           vertex_row;
    logic [VERTEX_COLUMN_W-1:0] vertex_column;
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
    logic                       last_of_run;
    logic                       last_of_grid;
    modport source (output valid, output vertex_row, output vertex_column, output normal_x,
                    output normal_y, output normal_z, output last_of_run,
                    output last_of_grid, input ready);
    modport sink (input valid, input vertex_row, input vertex_column, input normal_x,
                  input normal_y, input normal_z, input last_of_run, input last_of_grid,
                  output ready);
endinterface

@@ hw/rtl/hvn_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on hvn_pkg.
interface hvn_cfg_if;
    import hvn_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/hvn_normalize.sv @@
// Iterative vector normaliser: exact rounded Q1.14 unit vector of a 3x20-bit vector.
// One multiplier, one shared subtractor for long division and square root. Uses hvn_pkg.
module hvn_normalize (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  hvn_pkg::sum_vec_t   vec,
    output logic                done,
    output hvn_pkg::normal_vec_t result_vec
);
    import hvn_pkg::*;

    localparam logic [4:0] DIV_TOP  = 5'd30;
    localparam logic [4:0] SQRT_TOP = 5'd15;

    typedef enum logic [2:0] {N_IDLE, N_SQ, N_MUL, N_DIV, N_SQRT, N_DONE} norm_state_t;

    norm_state_t             state_reg;
    sum_vec_t                vec_reg;
    normal_vec_t             res_reg;
    logic [1:0]              idx_reg;
    logic [35:0]             s_reg;
    logic [36:0]             rem_reg;
    logic [30:0]             quo_reg;
    logic [31:0]             op_reg;
    logic [15:0]             root_reg;
    logic [4:0]              cnt_reg;

    logic signed [SUM_W-1:0] sel;
    logic [SUM_W-1:0]        mag_full;
    logic [17:0]             mag;
    logic [35:0]             prod;
    logic [37:0]             sub_a;
    logic [37:0]             sub_b;
    logic [38:0]             diff;
    logic                    fits;
    logic [36:0]             rem_next;
    logic [30:0]             quo_next;
    logic [15:0]             root_next;
    logic [16:0]             m_full;
    logic [NORMAL_W-1:0]     m_signed;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel = vec_reg.x;
            2'd1:    sel = vec_reg.y;
            default: sel = vec_reg.z;
        endcase
        mag_full = sel[SUM_W-1] ? SUM_W'(-sel) : SUM_W'(sel);
        mag      = mag_full[17:0];
        prod     = mag * mag;

        case (state_reg)
            N_DIV:
            begin
                sub_a = (cnt_reg == DIV_TOP) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
                sub_b = {2'b0, s_reg};
            end
            N_SQRT:
            begin
                sub_a = {16'b0, rem_reg[19:0], op_reg[31:30]};
                sub_b = {20'b0, root_reg, 2'b01};
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
        diff      = {1'b0, sub_a} - {1'b0, sub_b};
        fits      = !diff[38];
        rem_next  = fits ? diff[36:0] : sub_a[36:0];
        quo_next  = {quo_reg[29:0], fits};
        root_next = {root_reg[14:0], fits};
        m_full    = (17'(root_next) + 17'd1) >> 1;
        m_signed  = sel[SUM_W-1] ? NORMAL_W'(-m_full) : NORMAL_W'(m_full);
    end

    assign done       = (state_reg == N_DONE);
    assign result_vec = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            idx_reg   <= 2'd0;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        vec_reg   <= vec;
                        s_reg     <= '0;
                        idx_reg   <= 2'd0;
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    s_reg <= s_reg + prod;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= 2'd0;
                        state_reg <= N_MUL;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 2'd1;
                    end
                end
                N_MUL:
                begin
                    rem_reg   <= {1'b0, prod};
                    quo_reg   <= '0;
                    cnt_reg   <= DIV_TOP;
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    if (cnt_reg == 5'd0)
                    begin
                        op_reg    <= {1'b0, quo_next};
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= SQRT_TOP;
                        state_reg <= N_SQRT;
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                        quo_reg <= quo_next;
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                N_SQRT:
                begin
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    op_reg   <= {op_reg[29:0], 2'b00};
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        case (idx_reg)
                            2'd0:    res_reg.x <= m_signed;
                            2'd1:    res_reg.y <= m_signed;
                            default: res_reg.z <= m_signed;
                        endcase
                        if (idx_reg == 2'd2)
                        begin
                            state_reg <= N_DONE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= N_MUL;
                        end
                    end
                end
                N_DONE:
                begin
                    state_reg <= N_IDLE;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/heightmap_vertex_normals.sv @@
// Top level of the height-map vertex normal block: sequencer, line stores, output register.
// Depends on hvn_pkg, the three channel interfaces, hvn_normalize and the assertion header.
//
// Usage:
//   heights: one unsigned Q8.8 height per transaction, raster order (rows, then columns).
//   normals: vertex normals in Q1.14 with row and column, last_of_run on the final
//            normal caused by a height, last_of_grid on the bottom-right vertex.
//   cfg:     register 0 is the row count, register 1 the column count. Any write
//            restarts the grid at row 0, column 0. Write only while idle.
// Timing:
//   Every normalisation runs in one shared unit, built from the 31-step division
//   and 16-step square root per component.
//   A height in row 0 or column 0 gives no normal.
//   Any other height takes two triangle normalisations plus one per normal, with
//   one to four normals per height, and takes longer while the output stalls.
//   heights.ready is high only between heights; one at a time is in work.
// Reset: positions and left height clear, registers return to 2 rows, 1024 columns.
// Stall: a held normal stays in the output register; the sequencer waits before
//   loading the next one until the earlier one is taken, which may be in the same cycle.
`include "heightmap_vertex_normals_assert.svh"

module heightmap_vertex_normals #(
    parameter int MAX_COLUMNS = hvn_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    hvn_height_if.sink   heights,
    hvn_normal_if.source normals,
    hvn_cfg_if.sink      cfg
);
    import hvn_pkg::*;

    localparam int CW   = $clog2(MAX_COLUMNS);
    localparam int CNTW = $clog2(MAX_COLUMNS + 1);
    localparam int CMPW = (CNTW > COLUMN_COUNT_W) ? CNTW : COLUMN_COUNT_W;

    typedef enum logic [3:0] {
        T_IDLE, T_LOAD, T_LT, T_RB_GO, T_RB, T_ACC, T_WR2, T_EGO, T_EWAIT, T_EPUSH, T_FINISH
    } top_state_t;

    top_state_t                 state_reg;
    logic [ROW_W-1:0]           row_count_reg;
    logic [COLUMN_COUNT_W-1:0]  col_count_reg;
    logic [ROW_W-1:0]           row_pos_reg;
    logic [CW-1:0]              col_pos_reg;
    logic [HEIGHT_W-1:0]        left_reg;
    logic [HEIGHT_W-1:0]        h_reg;
    logic [HEIGHT_W-1:0]        h00_reg;
    sum_vec_t                   up_carry_reg;
    sum_vec_t                   low_carry_reg;
    sum_vec_t                   lt_reg;
    sum_vec_t                   e_reg [4];
    logic [3:0]                 e_en_reg;
    logic [1:0]                 e_idx_reg;

    logic                       out_valid_reg;
    logic [ROW_W-1:0]           out_row_reg;
    logic [VERTEX_COLUMN_W-1:0] out_col_reg;
    normal_vec_t                out_n_reg;
    logic                       out_run_reg;
    logic                       out_grid_reg;

    logic [HEIGHT_W-1:0]        prev_mem [MAX_COLUMNS];
    sum_vec_t                   sum_mem [MAX_COLUMNS];
    logic [HEIGHT_W-1:0]        prev_rd_reg;
    sum_vec_t                   sum_rd_reg;

    logic                       in_fire;
    logic [CMPW-1:0]            cc_ext;
    logic [CNTW-1:0]            cols_eff;
    logic [ROW_W-1:0]           rows_eff;
    logic                       last_col;
    logic                       last_row;
    logic                       interior;
    logic [CW-1:0]              col_m1;
    logic                       sum_we;
    logic [CW-1:0]              sum_addr;
    sum_vec_t                   sum_wdata;
    logic                       norm_start;
    sum_vec_t                   norm_vec;
    logic                       norm_done;
    normal_vec_t                norm_res;
    sum_vec_t                   rb_w;
    sum_vec_t                   lt_rb;
    logic                       more;
    logic                       slot_free;

    assign in_fire   = heights.valid && heights.ready;
    assign cc_ext    = CMPW'(col_count_reg);
    assign cols_eff  = (cc_ext < CMPW'(2)) ? CNTW'(2) :
                       (cc_ext > CMPW'(MAX_COLUMNS)) ? CNTW'(MAX_COLUMNS) : CNTW'(cc_ext);
    assign rows_eff  = (row_count_reg < ROW_W'(2)) ? ROW_W'(2) : row_count_reg;
    assign last_col  = (CNTW'(col_pos_reg) == cols_eff - CNTW'(1));
    assign last_row  = (row_pos_reg == rows_eff - ROW_W'(1));
    assign interior  = (row_pos_reg != '0) && (col_pos_reg != '0);
    assign col_m1    = col_pos_reg - CW'(1);
    assign rb_w      = widen(norm_res);
    assign lt_rb     = vec_add(lt_reg, rb_w);
    assign more      = |(e_en_reg & 4'(4'b1110 << e_idx_reg));
    assign slot_free = !out_valid_reg || normals.ready;

    always_comb
    begin
        norm_start = 1'b0;
        norm_vec   = e_reg[e_idx_reg];
        sum_we     = 1'b0;
        sum_addr   = col_pos_reg;
        sum_wdata  = '0;
        case (state_reg)
            T_LOAD:
            begin
                norm_start = interior;
                norm_vec.x = SUM_W'({4'b0, left_reg}) - SUM_W'({4'b0, h00_reg});
                norm_vec.y = NEG_GRID_UNIT;
                norm_vec.z = SUM_W'({4'b0, prev_rd_reg}) - SUM_W'({4'b0, h00_reg});
                sum_we     = (row_pos_reg == '0);
            end
            T_RB_GO:
            begin
                norm_start = 1'b1;
                norm_vec.x = SUM_W'({4'b0, h_reg}) - SUM_W'({4'b0, prev_rd_reg});
                norm_vec.y = NEG_GRID_UNIT;
                norm_vec.z = SUM_W'({4'b0, h_reg}) - SUM_W'({4'b0, left_reg});
            end
            T_ACC:
            begin
                sum_we    = 1'b1;
                sum_addr  = col_m1;
                sum_wdata = vec_add(low_carry_reg, lt_reg);
            end
            T_WR2:
            begin
                sum_we    = 1'b1;
                sum_wdata = low_carry_reg;
            end
            T_EGO:
            begin
                norm_start = e_en_reg[e_idx_reg];
            end
            default:
            begin
                norm_start = 1'b0;
            end
        endcase
    end

    hvn_normalize u_normalize (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (norm_start),
        .vec        (norm_vec),
        .done       (norm_done),
        .result_vec (norm_res)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            prev_rd_reg           <= prev_mem[col_pos_reg];
            sum_rd_reg            <= sum_mem[col_pos_reg];
            prev_mem[col_pos_reg] <= heights.height;
        end
        if (sum_we)
        begin
            sum_mem[sum_addr] <= sum_wdata;
        end
    end

    assign heights.ready        = (state_reg == T_IDLE);
    assign cfg.ready            = 1'b1;
    assign normals.valid        = out_valid_reg;
    assign normals.vertex_row   = out_row_reg;
    assign normals.vertex_column = out_col_reg;
    assign normals.normal_x     = out_n_reg.x;
    assign normals.normal_y     = out_n_reg.y;
    assign normals.normal_z     = out_n_reg.z;
    assign normals.last_of_run  = out_run_reg;
    assign normals.last_of_grid = out_grid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            row_count_reg <= ROW_COUNT_RESET;
            col_count_reg <= COLUMN_COUNT_RESET;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            left_reg      <= '0;
            e_en_reg      <= '0;
            e_idx_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (normals.valid && normals.ready && (state_reg != T_EPUSH))
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_ROW_COUNT:    row_count_reg <= cfg.data;
                    REG_COLUMN_COUNT: col_count_reg <= cfg.data[COLUMN_COUNT_W-1:0];
                    default:          row_count_reg <= row_count_reg;
                endcase
                row_pos_reg <= '0;
                col_pos_reg <= '0;
                left_reg    <= '0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (in_fire)
                    begin
                        h_reg     <= heights.height;
                        state_reg <= T_LOAD;
                    end
                end
                T_LOAD:
                begin
                    if (row_pos_reg == '0)
                    begin
                        state_reg <= T_FINISH;
                    end
                    else if (col_pos_reg == '0)
                    begin
                        h00_reg       <= prev_rd_reg;
                        up_carry_reg  <= sum_rd_reg;
                        low_carry_reg <= '0;
                        state_reg     <= T_FINISH;
                    end
                    else
                    begin
                        state_reg <= T_LT;
                    end
                end
                T_LT:
                begin
                    if (norm_done)
                    begin
                        lt_reg    <= widen(norm_res);
                        state_reg <= T_RB_GO;
                    end
                end
                T_RB_GO:
                begin
                    state_reg <= T_RB;
                end
                T_RB:
                begin
                    if (norm_done)
                    begin
                        lt_reg        <= lt_rb;
                        e_reg[0]      <= vec_add(up_carry_reg, vec_add(lt_reg, lt_reg));
                        e_reg[1]      <= vec_add(sum_rd_reg, lt_rb);
                        e_reg[2]      <= vec_add(low_carry_reg, lt_rb);
                        e_reg[3]      <= vec_add(rb_w, rb_w);
                        up_carry_reg  <= vec_add(sum_rd_reg, lt_rb);
                        e_en_reg      <= {last_row && last_col, last_row, last_col, 1'b1};
                        e_idx_reg     <= 2'd0;
                        h00_reg       <= prev_rd_reg;
                        state_reg     <= T_ACC;
                    end
                end
                T_ACC:
                begin
                    low_carry_reg <= e_reg[3];
                    state_reg     <= last_col ? T_WR2 : T_EGO;
                end
                T_WR2:
                begin
                    state_reg <= T_EGO;
                end
                T_EGO:
                begin
                    if (e_en_reg[e_idx_reg])
                    begin
                        state_reg <= T_EWAIT;
                    end
                    else if (e_idx_reg == 2'd3)
                    begin
                        state_reg <= T_FINISH;
                    end
                    else
                    begin
                        e_idx_reg <= e_idx_reg + 2'd1;
                    end
                end
                T_EWAIT:
                begin
                    if (norm_done)
                    begin
                        state_reg <= T_EPUSH;
                    end
                end
                T_EPUSH:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_row_reg   <= e_idx_reg[1] ? row_pos_reg : row_pos_reg - ROW_W'(1);
                        out_col_reg   <= VERTEX_COLUMN_W'(e_idx_reg[0] ? col_pos_reg : col_m1);
                        out_n_reg     <= norm_res;
                        out_run_reg   <= !more;
                        out_grid_reg  <= (e_idx_reg == 2'd3);
                        if (more)
                        begin
                            e_idx_reg <= e_idx_reg + 2'd1;
                            state_reg <= T_EGO;
                        end
                        else
                        begin
                            state_reg <= T_FINISH;
                        end
                    end
                end
                T_FINISH:
                begin
                    left_reg <= h_reg;
                    if (last_col)
                    begin
                        col_pos_reg <= '0;
                        row_pos_reg <= last_row ? '0 : row_pos_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_pos_reg <= col_pos_reg + CW'(1);
                    end
                    state_reg <= T_IDLE;
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    `HVN_ASSERT_NEXT(a_one_item, in_fire, !heights.ready, "height taken while busy")
    `HVN_ASSERT_NOW(a_done_awaited, norm_done, (state_reg == T_LT) || (state_reg == T_RB) || (state_reg == T_EWAIT), "normaliser finished unexpectedly")
    `HVN_ASSERT_NOW(a_y_down, normals.valid, normals.normal_y <= 0, "normal points upward")
    `HVN_ASSERT_NOW(a_grid_ends_run, normals.valid && normals.last_of_grid, normals.last_of_run, "grid end not last of run")

endmodule
